[rtl/wewd_pkg.sv]
// shared types and constants for the window extremum event detector
// no dependencies

package wewd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int KIND_W     = 2;
    localparam int WLEN_W     = 6;
    localparam int THR_W      = 15;
    localparam int CFG_DATA_W = 15;
    localparam int CFG_IDX_W  = 1;
    // wide enough for any window length the block supports (up to 63)
    localparam int LEN_W      = 7;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_THRESHOLD = 1'b1;

    localparam logic [WLEN_W-1:0] WINDOW_LEN_RESET      = 6'd9;
    localparam logic [THR_W-1:0]  DEPTH_THRESHOLD_RESET = 15'd50;
    localparam logic [LEN_W-1:0]  MIN_LEN               = 7'd3;

    localparam logic [KIND_W-1:0] EVT_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] EVT_RIDGE  = 2'd1;
    localparam logic [KIND_W-1:0] EVT_VALLEY = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] vmax;
        logic signed [SAMPLE_W-1:0] vmin;
        logic                       lowest;
        logic                       highest;
    } probe_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] vm;
        logic [LEN_W-1:0]           len;
        logic [LEN_W-1:0]           mid;
    } scan_ctl_t;

endpackage

[rtl/wewd_cell.sv]
// one cell of the sample chain: holds one sample and folds it into the passing probe
// depends on wewd_pkg

module wewd_cell #(
    parameter int CELL_INDEX = 0
) (
    input  logic                                clk,
    input  logic                                shift_en,
    input  logic                                adv_en,
    input  logic signed [wewd_pkg::SAMPLE_W-1:0] sample_in,
    input  wewd_pkg::probe_t                    probe_in,
    input  wewd_pkg::scan_ctl_t                 ctl,
    output logic signed [wewd_pkg::SAMPLE_W-1:0] sample_out,
    output wewd_pkg::probe_t                    probe_out
);

    logic signed [wewd_pkg::SAMPLE_W-1:0] sample_reg;
    wewd_pkg::probe_t                     probe_reg;
    wewd_pkg::probe_t                     probe_next;
    logic                                 in_window;

    assign in_window = (wewd_pkg::LEN_W'(CELL_INDEX) < ctl.len)
                    && (wewd_pkg::LEN_W'(CELL_INDEX) != ctl.mid);

    always_comb
    begin
        probe_next = probe_in;
        if (in_window)
        begin
            if (sample_reg > probe_in.vmax)
                probe_next.vmax = sample_reg;
            if (sample_reg < probe_in.vmin)
                probe_next.vmin = sample_reg;
            if (sample_reg <= ctl.vm)
                probe_next.lowest = 1'b0;
            if (sample_reg >= ctl.vm)
                probe_next.highest = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
            sample_reg <= sample_in;
        if (adv_en)
            probe_reg <= probe_next;
    end

    assign sample_out = sample_reg;
    assign probe_out  = probe_reg;

endmodule

[rtl/window_extremum_event_detector_core.sv]
// top level of the window extremum event detector: cell chain, sequencer, output register
// depends on wewd_pkg and wewd_cell

// Each transferred sample enters a shift chain of MAX_WINDOW cells, newest in cell 0.
// The block then latches the middle sample and walks a probe down the whole chain, one
// cell per cycle, gathering window maximum, minimum and the strict-extremum flags. No
// new sample is taken until the scan is done and the result has gone to the output
// register, which waits while a previous result still sits there under an output
// stall. Every sample yields exactly one result. Window length is clamped to
// 3..MAX_WINDOW; until that many samples have been seen the result is no event with a
// zero middle value.

module window_extremum_event_detector_core #(
    parameter int MAX_WINDOW = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [wewd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [wewd_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [wewd_pkg::SAMPLE_W-1:0] height_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [wewd_pkg::KIND_W-1:0]          event_kind,
    output logic signed [wewd_pkg::SAMPLE_W-1:0] middle_value
);

    localparam int IDX_W = $clog2(MAX_WINDOW);
    localparam int LEN_W = wewd_pkg::LEN_W;
    localparam int SW    = wewd_pkg::SAMPLE_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOAD = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [wewd_pkg::WLEN_W-1:0] window_len_reg;
    logic [wewd_pkg::THR_W-1:0]  depth_threshold_reg;
    logic [LEN_W-1:0]            fill_reg, fill_next;
    logic [LEN_W-1:0]            eff_len;
    logic [LEN_W-1:0]            len_reg;
    logic                        full_reg;
    logic [IDX_W-1:0]            cnt_reg;
    logic signed [SW-1:0]        vm_reg;

    logic                        out_valid_reg;
    logic [wewd_pkg::KIND_W-1:0] kind_reg;
    logic signed [SW-1:0]        mid_val_reg;

    logic                        in_xfer;
    logic                        out_free;
    logic                        shift_en;
    logic                        adv_en;
    wewd_pkg::scan_ctl_t         ctl;
    wewd_pkg::probe_t            probe_init;
    wewd_pkg::probe_t            probe_last;

    logic signed [SW-1:0]        sample_chain [MAX_WINDOW];
    wewd_pkg::probe_t            probe_chain  [MAX_WINDOW];

    logic signed [SW:0]          rise_above;
    logic signed [SW:0]          drop_below;
    logic signed [SW:0]          thr_ext;
    logic                        is_ridge;
    logic                        is_valley;
    logic [wewd_pkg::KIND_W-1:0] kind_next;
    logic signed [SW-1:0]        mid_val_next;

    assign in_xfer  = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign shift_en = in_xfer;
    assign adv_en   = (state_reg == S_SCAN);

    // clamp to 3..MAX_WINDOW
    always_comb
    begin
        if (LEN_W'(window_len_reg) < wewd_pkg::MIN_LEN)
            eff_len = wewd_pkg::MIN_LEN;
        else if (LEN_W'(window_len_reg) > LEN_W'(MAX_WINDOW))
            eff_len = LEN_W'(MAX_WINDOW);
        else
            eff_len = LEN_W'(window_len_reg);
    end

    assign fill_next = (fill_reg < eff_len) ? fill_reg + LEN_W'(1) : fill_reg;

    assign ctl.vm  = vm_reg;
    assign ctl.len = len_reg;
    assign ctl.mid = len_reg >> 1;

    assign probe_init.vmax    = vm_reg;
    assign probe_init.vmin    = vm_reg;
    assign probe_init.lowest  = 1'b1;
    assign probe_init.highest = 1'b1;

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++)
        begin : g_cell
            if (g == 0)
            begin : g_head
                wewd_cell #(
                    .CELL_INDEX (g)
                ) u_cell (
                    .clk        (clk),
                    .shift_en   (shift_en),
                    .adv_en     (adv_en),
                    .sample_in  (height_sample),
                    .probe_in   (probe_init),
                    .ctl        (ctl),
                    .sample_out (sample_chain[g]),
                    .probe_out  (probe_chain[g])
                );
            end
            else
            begin : g_body
                wewd_cell #(
                    .CELL_INDEX (g)
                ) u_cell (
                    .clk        (clk),
                    .shift_en   (shift_en),
                    .adv_en     (adv_en),
                    .sample_in  (sample_chain[g-1]),
                    .probe_in   (probe_chain[g-1]),
                    .ctl        (ctl),
                    .sample_out (sample_chain[g]),
                    .probe_out  (probe_chain[g])
                );
            end
        end
    endgenerate

    assign probe_last = probe_chain[MAX_WINDOW-1];

    assign rise_above = (SW+1)'(probe_last.vmax) - (SW+1)'(vm_reg);
    assign drop_below = (SW+1)'(vm_reg) - (SW+1)'(probe_last.vmin);
    assign thr_ext    = signed'({2'b00, depth_threshold_reg});
    assign is_ridge   = full_reg && probe_last.lowest && (rise_above > thr_ext);
    assign is_valley  = full_reg && probe_last.highest && (drop_below > thr_ext);

    always_comb
    begin
        kind_next    = wewd_pkg::EVT_NONE;
        mid_val_next = '0;
        if (is_ridge)
        begin
            kind_next    = wewd_pkg::EVT_RIDGE;
            mid_val_next = vm_reg;
        end
        else if (is_valley)
        begin
            kind_next    = wewd_pkg::EVT_VALLEY;
            mid_val_next = vm_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                    state_next = S_LOAD;
            end
            S_LOAD:
                state_next = S_SCAN;
            S_SCAN:
            begin
                if (cnt_reg == IDX_W'(MAX_WINDOW - 1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            window_len_reg      <= wewd_pkg::WINDOW_LEN_RESET;
            depth_threshold_reg <= wewd_pkg::DEPTH_THRESHOLD_RESET;
            fill_reg            <= '0;
            full_reg            <= 1'b0;
            len_reg             <= wewd_pkg::MIN_LEN;
            cnt_reg             <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    wewd_pkg::REG_WINDOW_LEN:
                        window_len_reg <= cfg_wr_data[wewd_pkg::WLEN_W-1:0];
                    wewd_pkg::REG_DEPTH_THRESHOLD:
                        depth_threshold_reg <= cfg_wr_data[wewd_pkg::THR_W-1:0];
                    default:
                        ;
                endcase
            end

            if (in_xfer)
            begin
                fill_reg <= fill_next;
                full_reg <= (fill_next >= eff_len);
                len_reg  <= eff_len;
            end

            if (state_reg == S_SCAN)
                cnt_reg <= cnt_reg + IDX_W'(1);
            else
                cnt_reg <= '0;

            if ((state_reg == S_DONE) && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD)
            vm_reg <= sample_chain[ctl.mid[IDX_W-1:0]];
        if ((state_reg == S_DONE) && out_free)
        begin
            kind_reg    <= kind_next;
            mid_val_reg <= mid_val_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign middle_value = mid_val_reg;

endmodule

[rtl/wewd_checker.sv]
// port-level checks for the window extremum event detector
// depends on wewd_pkg; bound to window_extremum_event_detector_core

module wewd_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic [wewd_pkg::KIND_W-1:0]          event_kind,
    input logic signed [wewd_pkg::SAMPLE_W-1:0] middle_value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(middle_value))
        else $error("stalled result changed");

    // only defined event codes leave the block
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (event_kind == wewd_pkg::EVT_NONE || event_kind == wewd_pkg::EVT_RIDGE
                       || event_kind == wewd_pkg::EVT_VALLEY))
        else $error("illegal event kind");

    // no event carries a zero middle value
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (event_kind == wewd_pkg::EVT_NONE) |-> (middle_value == '0))
        else $error("middle value set without event");

    // block is busy after a sample transfer
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second sample taken while scanning");

endmodule

bind window_extremum_event_detector_core wewd_checker u_wewd_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// testbench for window_extremum_event_detector_core: directed and random height samples
// checked against a scoreboard class that predicts ridge and valley events
// depends on wewd_pkg and the detector rtl

class event_scoreboard;
    localparam int RING = 32;

    logic signed [wewd_pkg::SAMPLE_W-1:0] ring [RING];
    int unsigned fill;
    int unsigned wpos;
    logic [wewd_pkg::WLEN_W-1:0] window_len;
    logic [wewd_pkg::THR_W-1:0] depth_threshold;
    logic [wewd_pkg::KIND_W-1:0] kind_q [$];
    logic signed [wewd_pkg::SAMPLE_W-1:0] value_q [$];
    int errors;

    function new();
        fill = 0;
        wpos = 0;
        window_len = wewd_pkg::WINDOW_LEN_RESET;
        depth_threshold = wewd_pkg::DEPTH_THRESHOLD_RESET;
        errors = 0;
    endfunction

    task flag_mismatch(string what);
        errors++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function void write_register(logic [wewd_pkg::CFG_IDX_W-1:0] idx,
                                 logic [wewd_pkg::CFG_DATA_W-1:0] data);
        if (idx == wewd_pkg::REG_WINDOW_LEN)
            window_len = data[wewd_pkg::WLEN_W-1:0];
        else if (idx == wewd_pkg::REG_DEPTH_THRESHOLD)
            depth_threshold = data[wewd_pkg::THR_W-1:0];
    endfunction

    function int unsigned span();
        int unsigned n;
        n = window_len;
        if (n < 3)
            n = 3;
        if (n > RING)
            n = RING;
        return n;
    endfunction

    function int older(int unsigned back);
        return ring[(wpos + RING - 1 - back) % RING];
    endfunction

    // one transfer in, one predicted event out
    function void note_sample(logic signed [wewd_pkg::SAMPLE_W-1:0] s);
        int unsigned len;
        int unsigned mid;
        int vm;
        int vmax;
        int vmin;
        int v;
        bit lowest;
        bit highest;
        logic [wewd_pkg::KIND_W-1:0] kind;
        logic signed [wewd_pkg::SAMPLE_W-1:0] mval;
        len = span();
        ring[wpos] = s;
        wpos = (wpos + 1) % RING;
        if (fill < len)
            fill++;
        kind = wewd_pkg::EVT_NONE;
        mval = '0;
        if (fill >= len)
        begin
            mid = len / 2;
            vm = older(mid);
            vmax = vm;
            vmin = vm;
            lowest = 1'b1;
            highest = 1'b1;
            for (int unsigned i = 0; i < len; i++)
            begin
                if (i != mid)
                begin
                    v = older(i);
                    if (v > vmax)
                        vmax = v;
                    if (v < vmin)
                        vmin = v;
                    if (v <= vm)
                        lowest = 1'b0;
                    if (v >= vm)
                        highest = 1'b0;
                end
            end
            if (lowest && (vmax - vm) > int'(depth_threshold))
            begin
                kind = wewd_pkg::EVT_RIDGE;
                mval = vm[wewd_pkg::SAMPLE_W-1:0];
            end
            else if (highest && (vm - vmin) > int'(depth_threshold))
            begin
                kind = wewd_pkg::EVT_VALLEY;
                mval = vm[wewd_pkg::SAMPLE_W-1:0];
            end
        end
        kind_q = {kind_q, kind};
        value_q = {value_q, mval};
    endfunction

    task check_result(logic [wewd_pkg::KIND_W-1:0] kind,
                      logic signed [wewd_pkg::SAMPLE_W-1:0] mval);
        logic [wewd_pkg::KIND_W-1:0] want_kind;
        logic signed [wewd_pkg::SAMPLE_W-1:0] want_val;
        if (kind_q.size() == 0)
        begin
            flag_mismatch($sformatf("result with nothing pending kind=%0d value=%0d",
                                    kind, mval));
        end
        else
        begin
            want_kind = kind_q[0];
            want_val = value_q[0];
            kind_q.delete(0);
            value_q.delete(0);
            if (kind !== want_kind)
                flag_mismatch($sformatf("event_kind got %0d want %0d", kind, want_kind));
            if (mval !== want_val)
                flag_mismatch($sformatf("middle_value got %0d want %0d", mval, want_val));
        end
    endtask

    function int pending();
        return kind_q.size();
    endfunction

    task check_leftover();
        if (kind_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", kind_q.size()));
    endtask
endclass

module tb;

    localparam int RING = 32;
    localparam int SETTLE = RING + 8;
    localparam int CYCLE_LIMIT = 600000;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [wewd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [wewd_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic in_valid;
    logic in_stall;
    logic signed [wewd_pkg::SAMPLE_W-1:0] height_sample;
    logic out_valid;
    logic out_stall;
    logic [wewd_pkg::KIND_W-1:0] event_kind;
    logic signed [wewd_pkg::SAMPLE_W-1:0] middle_value;

    event_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int unsigned cycles = 0;

    int unsigned phase_len [12] = '{1, 63, 5, 32, 2, 33, 17, 3, 0, 12, 9, 24};
    int unsigned phase_thr [12] = '{0, 40, 32767, 300, 7, 0, 1500, 20000, 12, 999, 50, 5};

    window_extremum_event_detector_core #(
        .MAX_WINDOW(RING)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .height_sample(height_sample),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_kind(event_kind),
        .middle_value(middle_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            out_stall = ($urandom_range(0, 99) < recv_idle_pct);
        else
            out_stall = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(event_kind, middle_value);
    end

    function automatic logic signed [wewd_pkg::SAMPLE_W-1:0] clip16(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[wewd_pkg::SAMPLE_W-1:0];
    endfunction

    task automatic send_sample(input logic signed [wewd_pkg::SAMPLE_W-1:0] s);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        height_sample = s;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_sample(s);
    endtask

    task automatic write_cfg(input logic [wewd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wewd_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wr_data = data;
        @(posedge clk);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    // block goes idle: every expected result back, then some spare cycles
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_window(input int unsigned wl, input int unsigned thr);
        write_cfg(wewd_pkg::REG_WINDOW_LEN, wewd_pkg::CFG_DATA_W'(wl & 6'h3f));
        write_cfg(wewd_pkg::REG_DEPTH_THRESHOLD, wewd_pkg::CFG_DATA_W'(thr & 15'h7fff));
    endtask

    // mix of full-range noise, near-ties, and isolated spikes sized around the threshold
    task automatic feed_random(input int n_items);
        int sent;
        int eff;
        int pick;
        int base;
        int dir;
        int amp;
        sent = 0;
        eff = sb.span();
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
            begin
                repeat (6)
                begin
                    send_sample(wewd_pkg::SAMPLE_W'($urandom));
                    sent++;
                end
            end
            else if (pick < 5)
            begin
                base = int'($urandom_range(0, 200)) - 100;
                repeat (6)
                begin
                    send_sample(clip16(base + int'($urandom_range(0, 2))));
                    sent++;
                end
            end
            else
            begin
                base = int'($urandom_range(0, 40000)) - 20000;
                dir = $urandom_range(0, 1) ? 1 : -1;
                amp = int'(sb.depth_threshold) + int'($urandom_range(0, 2)) - 2;
                for (int k = 0; k < eff + 3; k++)
                begin
                    if (k == eff / 2 + 1)
                        send_sample(clip16(base + dir * amp));
                    else
                        send_sample(clip16(base - dir * int'($urandom_range(0, 1))));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        send_idle_pct = 14;
        recv_idle_pct = 68;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = wewd_pkg::REG_WINDOW_LEN;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        height_sample = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset config: fill, then an isolated dip in the middle
        send_sample(16'sd5);
        send_sample(16'sd5);
        send_sample(16'sd5);
        send_sample(16'sd5);
        send_sample(-16'sd60);
        send_sample(16'sd5);
        send_sample(16'sd5);
        send_sample(16'sd5);
        send_sample(16'sd5);
        send_sample(16'sd5);
        drain();

        // shortest window, prominence just over the threshold, then a peak
        set_window(3, 99);
        send_sample(16'sd100);
        send_sample(16'sd0);
        send_sample(16'sd100);
        send_sample(16'sd0);
        drain();

        // prominence equal to the threshold gives nothing
        set_window(3, 100);
        send_sample(16'sd100);
        send_sample(16'sd0);
        send_sample(16'sd100);
        drain();

        // length below range clamps to 3; full-scale swings against the largest threshold
        set_window(0, 32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            if (p < 4)
            begin
                send_idle_pct = 14;
                recv_idle_pct = 68;
            end
            else if (p < 8)
            begin
                send_idle_pct = 68;
                recv_idle_pct = 14;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 9)
                phase_thr[p] = $urandom_range(0, 32767);
            set_window(phase_len[p], phase_thr[p]);
            feed_random(100);
            drain();
        end

        sb.check_leftover();
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
